[sv/tsd_pkg.sv]
package tsd_pkg;

  localparam int SIDE_DEPTH_DEF = 512;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int REQ_W    = 3;
  localparam int POS_W    = 10;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 11;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ_AT    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE_AT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_BACK  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic SIDE_FRONT = 1'b0;
  localparam logic SIDE_BACK  = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                side;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  total_count;
    logic                is_empty;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data_out;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  total_count;
    logic                is_empty;
  } res_t;

endpackage

[sv/tsd_ram.sv]
module tsd_ram #(
  parameter int WIDTH = tsd_pkg::ELEM_WIDTH_DEF,
  parameter int DEPTH = tsd_pkg::SIDE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/tsd_fifo.sv]
module tsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tsd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

[sv/tsd_front.sv]
module tsd_front #(
  parameter int SIDE_DEPTH = tsd_pkg::SIDE_DEPTH_DEF,
  parameter int ELEM_WIDTH = tsd_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [tsd_pkg::REQ_W-1:0]     in_req_type,
  input  logic [tsd_pkg::POS_W-1:0]     in_position,
  input  logic [tsd_pkg::DATA_W-1:0]    in_data_in,
  input  logic                          q_full,
  output logic                          q_push,
  output tsd_pkg::cmd_t                 q_cmd,
  output logic [$clog2(SIDE_DEPTH)-1:0] q_addr,
  output logic [ELEM_WIDTH-1:0]         q_wdata
);

  localparam int AW   = $clog2(SIDE_DEPTH);
  localparam int CW   = $clog2(SIDE_DEPTH + 1);
  localparam int TW   = CW + 1;
  localparam int CMPW = (TW > tsd_pkg::POS_W) ? TW : tsd_pkg::POS_W;

  logic [CW-1:0] fc_r, fc_nxt;
  logic [CW-1:0] bc_r, bc_nxt;
  logic          accept;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;
  assign q_push  = accept;
  assign q_wdata = ELEM_WIDTH'(64'(in_data_in));

  always_comb begin
    logic [CMPW-1:0] fc_x, bc_x, pos_x, tot_x, ia_f, ia_b;
    logic [TW-1:0]   tot_nxt;
    fc_x  = CMPW'(fc_r);
    bc_x  = CMPW'(bc_r);
    pos_x = CMPW'(in_position);
    tot_x = fc_x + bc_x;
    ia_f  = fc_x - pos_x - CMPW'(1);
    ia_b  = pos_x - fc_x;

    fc_nxt       = fc_r;
    bc_nxt       = bc_r;
    q_cmd.op     = tsd_pkg::OP_NONE;
    q_cmd.side   = tsd_pkg::SIDE_FRONT;
    q_cmd.status = tsd_pkg::ST_OK;
    q_addr       = '0;

    unique case (in_req_type)
      tsd_pkg::REQ_PUSH_FRONT: begin
        if (fc_r == CW'(SIDE_DEPTH)) begin
          q_cmd.status = tsd_pkg::ST_FULL;
        end else begin
          q_cmd.op = tsd_pkg::OP_WRITE;
          q_addr   = fc_r[AW-1:0];
          fc_nxt   = fc_r + 1'b1;
        end
      end
      tsd_pkg::REQ_PUSH_BACK: begin
        if (bc_r == CW'(SIDE_DEPTH)) begin
          q_cmd.status = tsd_pkg::ST_FULL;
        end else begin
          q_cmd.op   = tsd_pkg::OP_WRITE;
          q_cmd.side = tsd_pkg::SIDE_BACK;
          q_addr     = bc_r[AW-1:0];
          bc_nxt     = bc_r + 1'b1;
        end
      end
      tsd_pkg::REQ_READ_AT, tsd_pkg::REQ_WRITE_AT: begin
        if (pos_x < tot_x) begin
          q_cmd.op = (in_req_type == tsd_pkg::REQ_WRITE_AT) ? tsd_pkg::OP_WRITE
                                                            : tsd_pkg::OP_READ;
          if (pos_x < fc_x) begin
            q_addr = ia_f[AW-1:0];
          end else begin
            q_cmd.side = tsd_pkg::SIDE_BACK;
            q_addr     = ia_b[AW-1:0];
          end
        end else begin
          q_cmd.status = tsd_pkg::ST_RANGE;
        end
      end
      tsd_pkg::REQ_READ_FRONT: begin
        if (fc_r != '0) begin
          q_cmd.op = tsd_pkg::OP_READ;
          q_addr   = AW'(fc_r - 1'b1);
        end else if (bc_r != '0) begin
          q_cmd.op   = tsd_pkg::OP_READ;
          q_cmd.side = tsd_pkg::SIDE_BACK;
        end else begin
          q_cmd.status = tsd_pkg::ST_RANGE;
        end
      end
      tsd_pkg::REQ_READ_BACK: begin
        if (bc_r != '0) begin
          q_cmd.op   = tsd_pkg::OP_READ;
          q_cmd.side = tsd_pkg::SIDE_BACK;
          q_addr     = AW'(bc_r - 1'b1);
        end else if (fc_r != '0) begin
          q_cmd.op = tsd_pkg::OP_READ;
        end else begin
          q_cmd.status = tsd_pkg::ST_RANGE;
        end
      end
      default: begin
        // unknown request: nothing changes, answer ok
      end
    endcase

    tot_nxt           = TW'(fc_nxt) + TW'(bc_nxt);
    q_cmd.total_count = tsd_pkg::TOTAL_W'(tot_nxt);
    q_cmd.is_empty    = (tot_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= '0;
      bc_r <= '0;
    end else if (accept) begin
      fc_r <= fc_nxt;
      bc_r <= bc_nxt;
    end
  end

endmodule

[sv/tsd_back.sv]
module tsd_back #(
  parameter int SIDE_DEPTH = tsd_pkg::SIDE_DEPTH_DEF,
  parameter int ELEM_WIDTH = tsd_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  tsd_pkg::cmd_t                 q_cmd,
  input  logic [$clog2(SIDE_DEPTH)-1:0] q_addr,
  input  logic [ELEM_WIDTH-1:0]         q_wdata,
  input  logic                          res_full,
  output logic                          res_push,
  output tsd_pkg::res_t                 res
);

  logic          s1_valid_r, s1_valid_nxt;
  tsd_pkg::cmd_t s1_cmd_r;
  logic          advance, issue;
  logic          f_en, b_en, ram_we;
  logic [ELEM_WIDTH-1:0] f_rdata, b_rdata, rd_sel;
  logic [63:0]   rd_ext;

  // read data stays in the ram output register while the stage stalls
  assign advance = !s1_valid_r || !res_full;
  assign issue   = !q_empty && advance;
  assign q_pop   = issue;

  assign ram_we = (q_cmd.op == tsd_pkg::OP_WRITE);
  assign f_en   = issue && (q_cmd.op != tsd_pkg::OP_NONE) && (q_cmd.side == tsd_pkg::SIDE_FRONT);
  assign b_en   = issue && (q_cmd.op != tsd_pkg::OP_NONE) && (q_cmd.side == tsd_pkg::SIDE_BACK);

  tsd_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (SIDE_DEPTH)
  ) u_front_ram (
    .clk   (clk),
    .en    (f_en),
    .we    (ram_we),
    .addr  (q_addr),
    .wdata (q_wdata),
    .rdata (f_rdata)
  );

  tsd_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (SIDE_DEPTH)
  ) u_back_ram (
    .clk   (clk),
    .en    (b_en),
    .we    (ram_we),
    .addr  (q_addr),
    .wdata (q_wdata),
    .rdata (b_rdata)
  );

  assign s1_valid_nxt = advance ? issue : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_cmd_r <= q_cmd;
    end
  end

  assign rd_sel   = (s1_cmd_r.side == tsd_pkg::SIDE_BACK) ? b_rdata : f_rdata;
  assign rd_ext   = 64'(rd_sel);
  assign res_push = s1_valid_r && !res_full;

  always_comb begin
    res.data_out    = (s1_cmd_r.op == tsd_pkg::OP_READ) ? rd_ext[tsd_pkg::DATA_W-1:0] : '0;
    res.status      = s1_cmd_r.status;
    res.total_count = s1_cmd_r.total_count;
    res.is_empty    = s1_cmd_r.is_empty;
  end

endmodule

[sv/two_stack_deque_top.sv]
// Double-ended queue kept as two stacks in two single-port rams, one for
// front pushes and one for back pushes. Requests go in through a queue-like
// port (push/full) and every request gives exactly one result on the
// result port (empty/pop), in request order. One request is taken per clock
// cycle when the result side keeps up. A request is written into the command
// queue; the ram stage reads its command straight out of that queue, the
// ram read is registered, and the result is then written into the result
// queue, whose head drives the out_ ports. Counts and status are settled
// at accept time, so only the ram access travels down the pipe.
module two_stack_deque_top #(
  parameter int SIDE_DEPTH = tsd_pkg::SIDE_DEPTH_DEF,
  parameter int ELEM_WIDTH = tsd_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [tsd_pkg::REQ_W-1:0]     in_req_type,
  input  logic [tsd_pkg::POS_W-1:0]     in_position,
  input  logic [tsd_pkg::DATA_W-1:0]    in_data_in,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [tsd_pkg::DATA_W-1:0]    out_data_out,
  output logic [tsd_pkg::STATUS_W-1:0]  out_status,
  output logic [tsd_pkg::TOTAL_W-1:0]   out_total_count,
  output logic                          out_is_empty
);

  localparam int AW = $clog2(SIDE_DEPTH);
  localparam int QW = $bits(tsd_pkg::cmd_t) + AW + ELEM_WIDTH;
  localparam int RW = $bits(tsd_pkg::res_t);

  logic                  q_push, q_full, q_pop, q_empty;
  tsd_pkg::cmd_t         fq_cmd, bq_cmd;
  logic [AW-1:0]         fq_addr, bq_addr;
  logic [ELEM_WIDTH-1:0] fq_wdata, bq_wdata;
  logic                  res_push, res_full;
  tsd_pkg::res_t         res_in, res_out;

  tsd_front #(
    .SIDE_DEPTH (SIDE_DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_req_type (in_req_type),
    .in_position (in_position),
    .in_data_in  (in_data_in),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (fq_cmd),
    .q_addr      (fq_addr),
    .q_wdata     (fq_wdata)
  );

  tsd_fifo #(
    .WIDTH (QW),
    .DEPTH (tsd_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   ({fq_cmd, fq_addr, fq_wdata}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  ({bq_cmd, bq_addr, bq_wdata}),
    .empty (q_empty)
  );

  tsd_back #(
    .SIDE_DEPTH (SIDE_DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_cmd    (bq_cmd),
    .q_addr   (bq_addr),
    .q_wdata  (bq_wdata),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  tsd_fifo #(
    .WIDTH (RW),
    .DEPTH (tsd_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign out_data_out    = res_out.data_out;
  assign out_status      = res_out.status;
  assign out_total_count = res_out.total_count;
  assign out_is_empty    = res_out.is_empty;

endmodule
